@@ hdl/mrpt_pkg.sv @@
// Shared constants for the Miller-Rabin round tester.
// No dependencies; used by miller_rabin_prime_test.
`default_nettype none

package mrpt_pkg;

  localparam int unsigned WIDTH_DEF = 64;
  localparam int unsigned WORD_W    = 64;

endpackage

`default_nettype wire

@@ hdl/miller_rabin_prime_test.sv @@
// Miller-Rabin round tester: one word per round, verdict word on the last round.
// Small or even candidates are decided without the multiplier; other rounds are paced by the
// bit-serial modular multiplier, which does at most 2*WIDTH-1 multiplies for reduction, power
// and squarings together.
// One round in flight at a time; input stall stays high until it completes. Reset
// (rst_ni low, asynchronous) idles the sequencer and sets the pass flag. Depends on mrpt_pkg.
`default_nettype none

module miller_rabin_prime_test #(
  parameter int unsigned WIDTH = mrpt_pkg::WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [mrpt_pkg::WORD_W-1:0] number_i,
  input  wire logic [mrpt_pkg::WORD_W-1:0] witness_i,
  input  wire logic                        last_round_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             probable_prime_o
);

  localparam int unsigned RW = $clog2(WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_MUL,
    ST_POW_INIT,
    ST_POW_BIT,
    ST_POW_MULD,
    ST_POW_SQR,
    ST_POW_SQD,
    ST_CHECK,
    ST_SQ_LOOP,
    ST_SQ_DONE,
    ST_FINISH
  } state_e;

  state_e           state_q, ret_q;
  logic [WIDTH-1:0] n_q, w_q, d_q, b_q, p_q;
  logic [WIDTH-1:0] m_acc_q, m_x_q, m_y_q;
  logic [RW-1:0]    r_q, j_q;
  logic             last_q, pass_q, passed_q;
  logic             out_valid_q, prime_q;

  logic [WIDTH-1:0] acc_d, x_d, nm1;
  logic             total;

  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  assign acc_d = m_y_q[0] ? add_mod(m_acc_q, m_x_q, n_q) : m_acc_q;
  assign x_d   = add_mod(m_x_q, m_x_q, n_q);
  assign nm1   = n_q - WIDTH'(1);
  assign total = passed_q & pass_q;

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign probable_prime_o = prime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      passed_q    <= 1'b1;
      out_valid_q <= 1'b0;
      prime_q     <= 1'b0;
      pass_q      <= 1'b0;
      last_q      <= 1'b0;
      r_q         <= '0;
      j_q         <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !(state_q == ST_FINISH && last_q)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q    <= number_i[WIDTH-1:0];
            w_q    <= witness_i[WIDTH-1:0];
            last_q <= last_round_i;
            d_q    <= number_i[WIDTH-1:0] - WIDTH'(1);
            r_q    <= '0;
            priority if (number_i[WIDTH-1:0] < WIDTH'(2)) begin
              pass_q  <= 1'b0;
              state_q <= ST_FINISH;
            end else if (number_i[WIDTH-1:0] < WIDTH'(4)) begin
              pass_q  <= 1'b1;
              state_q <= ST_FINISH;
            end else if (!number_i[0]) begin
              pass_q  <= 1'b0;
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_STRIP;
            end
          end
        end
        ST_STRIP: begin
          if (!d_q[0]) begin
            d_q <= d_q >> 1;
            r_q <= r_q + RW'(1);
          end else begin
            m_acc_q <= '0;
            m_x_q   <= WIDTH'(1);
            m_y_q   <= w_q;
            ret_q   <= ST_POW_INIT;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (m_y_q == '0) begin
            state_q <= ret_q;
          end else begin
            m_acc_q <= acc_d;
            m_x_q   <= x_d;
            m_y_q   <= m_y_q >> 1;
          end
        end
        ST_POW_INIT: begin
          b_q     <= m_acc_q;
          p_q     <= WIDTH'(1);
          state_q <= ST_POW_BIT;
        end
        ST_POW_BIT: begin
          priority if (d_q == '0) begin
            state_q <= ST_CHECK;
          end else if (d_q[0]) begin
            m_acc_q <= '0;
            m_x_q   <= b_q;
            m_y_q   <= p_q;
            ret_q   <= ST_POW_MULD;
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_POW_SQR;
          end
        end
        ST_POW_MULD: begin
          p_q     <= m_acc_q;
          state_q <= ST_POW_SQR;
        end
        ST_POW_SQR: begin
          m_acc_q <= '0;
          m_x_q   <= b_q;
          m_y_q   <= b_q;
          ret_q   <= ST_POW_SQD;
          state_q <= ST_MUL;
        end
        ST_POW_SQD: begin
          b_q     <= m_acc_q;
          d_q     <= d_q >> 1;
          state_q <= ST_POW_BIT;
        end
        ST_CHECK: begin
          if (p_q == WIDTH'(1) || p_q == nm1) begin
            pass_q  <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            j_q     <= RW'(1);
            state_q <= ST_SQ_LOOP;
          end
        end
        ST_SQ_LOOP: begin
          if (j_q < r_q) begin
            m_acc_q <= '0;
            m_x_q   <= p_q;
            m_y_q   <= p_q;
            ret_q   <= ST_SQ_DONE;
            state_q <= ST_MUL;
          end else begin
            pass_q  <= 1'b0;
            state_q <= ST_FINISH;
          end
        end
        ST_SQ_DONE: begin
          p_q <= m_acc_q;
          j_q <= j_q + RW'(1);
          if (m_acc_q == nm1) begin
            pass_q  <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_SQ_LOOP;
          end
        end
        ST_FINISH: begin
          if (!last_q) begin
            passed_q <= total;
            state_q  <= ST_IDLE;
          end else if (!(out_valid_q && out_stall_i)) begin
            out_valid_q <= 1'b1;
            prime_q     <= total;
            passed_q    <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_mul_operands_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (m_acc_q < n_q && m_x_q < n_q))
    else $error("multiplier operand not below modulus");

  a_power_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POW_BIT) |-> (p_q < n_q && b_q < n_q))
    else $error("power accumulator not below modulus");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH && last_q))
    else $error("verdict raised outside a last round");

  a_square_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ_DONE) |-> (j_q < r_q))
    else $error("squaring beyond r-1");

  a_flag_rearmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> passed_q)
    else $error("pass flag not re-armed after verdict");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for miller_rabin_prime_test: a directed table of rounds, then random
// tests; each verdict is checked against a fixed table value or against a predictor that does
// the modular arithmetic exactly. Depends on mrpt_pkg and the miller_rabin_prime_test RTL.
`default_nettype none

module tb;

  localparam int W = mrpt_pkg::WORD_W;

  localparam logic [W-1:0] PRIMES [8] = '{
    64'd18446744073709551557, 64'hFFFF_FFFF_FFFF_FFAD, 64'd9223372036854775783,
    64'd2305843009213693951, 64'd4294967291, 64'd4294967279, 64'd1000000007,
    64'd998244353
  };
  localparam logic [W-1:0] PSEUDOPRIMES [8] = '{
    64'd2047, 64'd1373653, 64'd25326001, 64'd3215031751, 64'd2152302898747,
    64'd3474749660383, 64'd341550071728321, 64'd3825123056546413051
  };

  typedef struct {
    logic [W-1:0] num;
    logic [W-1:0] wit;
    logic         last;
    logic         fixed;
    logic         verdict;
  } round_word_t;

  logic         clk_i        = 1'b0;
  logic         rst_ni       = 1'b0;
  logic         in_valid_i   = 1'b0;
  logic [W-1:0] number_i     = '0;
  logic [W-1:0] witness_i    = '0;
  logic         last_round_i = 1'b0;
  logic         out_stall_i  = 1'b0;
  logic         in_stall_o;
  logic         out_valid_o;
  logic         probable_prime_o;

  round_word_t  directed_rounds [$];
  logic         verdicts_due [$];
  logic         verdict_head;
  logic         passed_so_far = 1'b1;
  int           send_idle_pct = 35;
  int           recv_idle_pct = 71;
  int           words_sent = 0;
  int           mismatches = 0;

  miller_rabin_prime_test u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .number_i        (number_i),
    .witness_i       (witness_i),
    .last_round_i    (last_round_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .probable_prime_o(probable_prime_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [W-1:0] mod_mul(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [2*W-1:0] prod;
    prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(prod % {{W{1'b0}}, m});
  endfunction

  function automatic logic [W-1:0] mod_pow(logic [W-1:0] b, logic [W-1:0] e,
                                           logic [W-1:0] m);
    logic [W-1:0] acc;
    acc = W'(1);
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, b, m);
      b = mod_mul(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic witness_passes(logic [W-1:0] n, logic [W-1:0] w);
    logic [W-1:0] d;
    logic [W-1:0] x;
    int           r;
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (!n[0]) return 1'b0;
    d = n - 1;
    r = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    x = mod_pow(w, d, n);
    if (x == 1 || x == n - 1) return 1'b1;
    for (int j = 1; j < r; j++) begin
      x = mod_mul(x, x, n);
      if (x == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_row(logic [W-1:0] num, logic [W-1:0] wit, logic last,
                                  logic fixed, logic verdict);
    round_word_t row;
    row.num     = num;
    row.wit     = wit;
    row.last    = last;
    row.fixed   = fixed;
    row.verdict = verdict;
    directed_rounds.push_back(row);
  endfunction

  function automatic logic [W-1:0] pick_candidate();
    logic [W-1:0] n;
    case ($urandom_range(9))
      0, 1, 2: n = {$urandom, $urandom} | W'(1);
      3, 4:    n = PRIMES[$urandom_range(7)];
      5:       n = PRIMES[$urandom_range(4, 7)] * PRIMES[$urandom_range(4, 7)];
      6:       n = PSEUDOPRIMES[$urandom_range(7)];
      7:       n = W'($urandom_range(5, 65535) | 1);
      8:       n = $urandom_range(1) ? {$urandom, $urandom} & ~W'(1) : W'($urandom_range(3));
      default: n = {$urandom, $urandom};
    endcase
    return n;
  endfunction

  function automatic logic [W-1:0] pick_witness(logic [W-1:0] n);
    logic [W-1:0] w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = W'(1);
      2:       w = n - 1;
      3:       w = n;
      4:       w = n + 1;
      5:       w = W'($urandom_range(2, 1000));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic push_round(input logic [W-1:0] num, input logic [W-1:0] wit,
                            input logic last, input logic fixed, input logic verdict);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    number_i     <= num;
    witness_i    <= wit;
    last_round_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (!witness_passes(num, wit)) passed_so_far = 1'b0;
    if (last) begin
      verdicts_due.push_back(fixed ? verdict : passed_so_far);
      passed_so_far = 1'b1;
    end
    words_sent++;
    if (words_sent == 35) begin
      send_idle_pct = 71;
      recv_idle_pct = 35;
    end else if (words_sent == 70) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected word, probable_prime %0b", $time, probable_prime_o);
        mismatches++;
      end else begin
        verdict_head = verdicts_due.pop_front();
        if (probable_prime_o !== verdict_head) begin
          $display("%0t: probable_prime expected %0b got %0b", $time, verdict_head,
                   probable_prime_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [W-1:0] num;
    int           rounds;

    add_row(64'd0, 64'd5, 1'b1, 1'b1, 1'b0);
    add_row(64'd1, 64'd0, 1'b1, 1'b1, 1'b0);
    add_row(64'd2, '1, 1'b1, 1'b1, 1'b1);
    add_row(64'd3, 64'd0, 1'b1, 1'b1, 1'b1);
    add_row(64'd4, 64'd3, 1'b1, 1'b1, 1'b0);
    add_row('1 - 1, 64'd2, 1'b1, 1'b1, 1'b0);
    add_row('1, 64'd2, 1'b1, 1'b0, 1'b0);
    add_row(PRIMES[0], 64'd2, 1'b0, 1'b0, 1'b0);
    add_row(PRIMES[0], '1, 1'b0, 1'b0, 1'b0);
    add_row(PRIMES[0], PRIMES[0] - 1, 1'b0, 1'b0, 1'b0);
    add_row(PRIMES[0], 64'd1, 1'b1, 1'b0, 1'b0);
    add_row(PRIMES[0], PRIMES[0], 1'b1, 1'b1, 1'b0);
    add_row(PRIMES[0], 64'd0, 1'b1, 1'b1, 1'b0);
    add_row(64'd2047, 64'd2, 1'b1, 1'b0, 1'b0);
    add_row(64'd2047, 64'd3, 1'b0, 1'b0, 1'b0);
    add_row(64'd2047, 64'd2, 1'b1, 1'b0, 1'b0);
    add_row(PRIMES[3], 64'd3, 1'b0, 1'b0, 1'b0);
    add_row(64'd561, 64'd2, 1'b0, 1'b0, 1'b0);
    add_row(PRIMES[3], 64'd5, 1'b1, 1'b0, 1'b0);
    add_row(64'd9, 64'd8, 1'b1, 1'b0, 1'b0);
    add_row(64'd5, 64'd4, 1'b1, 1'b0, 1'b0);
    add_row(64'd0, 64'd0, 1'b0, 1'b0, 1'b0);
    add_row(64'd3, 64'd7, 1'b1, 1'b1, 1'b0);
    add_row(64'd3215031751, 64'd2, 1'b1, 1'b0, 1'b0);
    add_row(64'd25326001, 64'd3, 1'b1, 1'b0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rounds[i]) begin
      push_round(directed_rounds[i].num, directed_rounds[i].wit, directed_rounds[i].last,
                 directed_rounds[i].fixed, directed_rounds[i].verdict);
    end

    while (words_sent < 100) begin
      rounds = $urandom_range(1, 4);
      num = pick_candidate();
      for (int i = 0; i < rounds; i++) begin
        if (i > 0 && $urandom_range(7) == 0) num = pick_candidate();
        push_round(num, pick_witness(num), i == rounds - 1, 1'b0, 1'b0);
      end
    end
    in_valid_i <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (13000) @(posedge clk_i);

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/mrpt_pkg.sv
hdl/miller_rabin_prime_test.sv
dv/tb.sv
